/* hw/rtl/circular_fifo_with_search_assert.svh */
// Assertion macros shared by the RTL modules.
`ifndef CIRCULAR_FIFO_WITH_SEARCH_ASSERT_SVH
`define CIRCULAR_FIFO_WITH_SEARCH_ASSERT_SVH

// Check a property at every rising edge, skipped while reset is held.
`define CFWS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Check a property at every rising edge, reset included.
`define CFWS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* hw/rtl/cfws_pkg.sv */
`timescale 1ns / 1ps

package cfws_pkg;

    localparam int DEPTH        = 128;
    localparam int ADDR_W       = $clog2(DEPTH);
    localparam int CNT_W        = $clog2(DEPTH + 1);
    localparam int DATA_W       = 32;
    localparam int OCC_W        = 8;
    localparam int REQ_W        = 2;
    localparam int STS_W        = 2;
    localparam int IN_TDATA_W   = DATA_W;
    localparam int OUT_FIELDS_W = 2 * DATA_W + 1 + OCC_W + 2;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    // Request codes
    localparam logic [REQ_W-1:0] REQ_PUSH   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_POP    = 2'd1;
    localparam logic [REQ_W-1:0] REQ_SEARCH = 2'd2;

    // Status codes
    localparam logic [STS_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STS_W-1:0] ST_EMPTY = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_FRONT = 4'b0010,
        S_SCAN  = 4'b0100,
        S_DONE  = 4'b1000
    } t_state;

    typedef struct packed {
        logic accept;
        logic scan;
        logic load_front;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic scan_done;
        logic out_free;
    } t_sts;

    function automatic logic [ADDR_W-1:0] wrap_inc(input logic [ADDR_W-1:0] idx);
        return (idx == ADDR_W'(DEPTH - 1)) ? '0 : idx + 1'b1;
    endfunction

endpackage

/* hw/rtl/cfws_ram.sv */
`timescale 1ns / 1ps

module cfws_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* hw/rtl/cfws_ctrl.sv */
`timescale 1ns / 1ps
`include "circular_fifo_with_search_assert.svh"

module cfws_ctrl (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    input  logic [cfws_pkg::REQ_W-1:0] i_req,
    output logic                      o_ready,
    input  cfws_pkg::t_sts            i_sts,
    output cfws_pkg::t_cmd            o_cmd
);

    cfws_pkg::t_state r_state;
    cfws_pkg::t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            cfws_pkg::S_IDLE: begin
                o_cmd.accept = i_valid;
                if (i_valid) begin
                    if (i_req == cfws_pkg::REQ_POP) begin
                        n_state = cfws_pkg::S_FRONT;
                    end else if (i_req == cfws_pkg::REQ_SEARCH) begin
                        n_state = cfws_pkg::S_SCAN;
                    end else begin
                        n_state = cfws_pkg::S_DONE;
                    end
                end
            end
            cfws_pkg::S_FRONT: begin
                o_cmd.load_front = 1'b1;
                n_state          = cfws_pkg::S_DONE;
            end
            cfws_pkg::S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.scan_done) begin
                    n_state = cfws_pkg::S_DONE;
                end
            end
            cfws_pkg::S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = cfws_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = cfws_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cfws_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_ready = (r_state == cfws_pkg::S_IDLE);

    `CFWS_ASSERT(a_accept_leaves_idle, i_clk, i_rst_n, (i_valid && o_ready) |=> (r_state != cfws_pkg::S_IDLE), "accepted word did not start work")
    `CFWS_ASSERT(a_emit_only_in_done, i_clk, i_rst_n, o_cmd.emit |-> (r_state == cfws_pkg::S_DONE && i_sts.out_free), "result emitted outside done state")

endmodule

/* hw/rtl/cfws_dp.sv */
`timescale 1ns / 1ps
`include "circular_fifo_with_search_assert.svh"

module cfws_dp (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  cfws_pkg::t_cmd                   i_cmd,
    output cfws_pkg::t_sts                   o_sts,
    input  logic [cfws_pkg::REQ_W-1:0]       i_req,
    input  logic signed [cfws_pkg::DATA_W-1:0] i_value,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [cfws_pkg::OUT_TDATA_W-1:0] o_out_data,
    output logic [cfws_pkg::STS_W-1:0]       o_out_status
);

    localparam int AW = cfws_pkg::ADDR_W;
    localparam int CW = cfws_pkg::CNT_W;
    localparam int DW = cfws_pkg::DATA_W;
    localparam int PAD_W = cfws_pkg::OUT_TDATA_W - cfws_pkg::OUT_FIELDS_W;

    logic [AW-1:0] r_head, n_head;
    logic [AW-1:0] r_tail, n_tail;
    logic [CW-1:0] r_count, n_count;
    logic [DW-1:0] r_front, n_front;
    logic [DW-1:0] r_rear, n_rear;
    logic [DW-1:0] r_key, n_key;
    logic [cfws_pkg::STS_W-1:0] r_status, n_status;
    logic r_found, n_found;
    logic [AW-1:0] r_scan_ptr, n_scan_ptr;
    logic [CW-1:0] r_scan_left, n_scan_left;
    logic r_cmp_vld, n_cmp_vld;
    logic r_out_valid, n_out_valid;
    logic [cfws_pkg::OUT_TDATA_W-1:0] r_out_data, n_out_data;
    logic [cfws_pkg::STS_W-1:0] r_out_status, n_out_status;

    logic          we;
    logic [AW-1:0] raddr;
    logic [DW-1:0] rdata;
    logic          is_empty;
    logic          is_full;

    assign raddr = i_cmd.scan ? r_scan_ptr : cfws_pkg::wrap_inc(r_head);
    assign we    = i_cmd.accept && (i_req == cfws_pkg::REQ_PUSH) && !is_full;

    cfws_ram #(
        .WIDTH (DW),
        .DEPTH (cfws_pkg::DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (r_tail),
        .i_wdata (i_value),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    assign is_empty = (r_count == '0);
    assign is_full  = (r_count == CW'(cfws_pkg::DEPTH));

    always_comb begin
        n_head       = r_head;
        n_tail       = r_tail;
        n_count      = r_count;
        n_front      = r_front;
        n_rear       = r_rear;
        n_key        = r_key;
        n_status     = r_status;
        n_found      = r_found;
        n_scan_ptr   = r_scan_ptr;
        n_scan_left  = r_scan_left;
        n_cmp_vld    = 1'b0;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_out_data   = r_out_data;
        n_out_status = r_out_status;

        if (i_cmd.accept) begin
            n_status = cfws_pkg::ST_DONE;
            n_found  = 1'b0;
            unique case (i_req)
                cfws_pkg::REQ_PUSH: begin
                    if (is_full) begin
                        n_status = cfws_pkg::ST_FULL;
                    end else begin
                        n_tail  = cfws_pkg::wrap_inc(r_tail);
                        n_count = r_count + 1'b1;
                        n_rear  = i_value;
                        if (is_empty) begin
                            n_front = i_value;
                        end
                    end
                end
                cfws_pkg::REQ_POP: begin
                    if (is_empty) begin
                        n_status = cfws_pkg::ST_EMPTY;
                    end else begin
                        n_head  = cfws_pkg::wrap_inc(r_head);
                        n_count = r_count - 1'b1;
                    end
                end
                cfws_pkg::REQ_SEARCH: begin
                    n_key       = i_value;
                    n_scan_ptr  = r_head;
                    n_scan_left = r_count;
                end
                default: begin
                    n_status = cfws_pkg::ST_DONE;
                end
            endcase
        end

        // One read issued per cycle, compared in the cycle after.
        if (i_cmd.scan) begin
            if (r_scan_left != '0) begin
                n_scan_ptr  = cfws_pkg::wrap_inc(r_scan_ptr);
                n_scan_left = r_scan_left - 1'b1;
                n_cmp_vld   = 1'b1;
            end
            if (r_cmp_vld && (rdata == r_key)) begin
                n_found = 1'b1;
            end
        end

        if (i_cmd.load_front) begin
            n_front = rdata;
        end

        if (i_cmd.emit) begin
            n_out_valid  = 1'b1;
            n_out_status = r_status;
            n_out_data   = {{PAD_W{1'b0}}, is_full, is_empty,
                            cfws_pkg::OCC_W'(r_count), r_found,
                            is_empty ? '0 : r_rear,
                            is_empty ? '0 : r_front};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_scan_left <= '0;
            r_cmp_vld   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_count     <= n_count;
            r_scan_left <= n_scan_left;
            r_cmp_vld   <= n_cmp_vld;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_front      <= n_front;
        r_rear       <= n_rear;
        r_key        <= n_key;
        r_status     <= n_status;
        r_found      <= n_found;
        r_scan_ptr   <= n_scan_ptr;
        r_out_data   <= n_out_data;
        r_out_status <= n_out_status;
    end

    assign o_sts.scan_done = (r_scan_left == '0) && !r_cmp_vld;
    assign o_sts.out_free  = !r_out_valid || i_out_ready;
    assign o_out_valid     = r_out_valid;
    assign o_out_data      = r_out_data;
    assign o_out_status    = r_out_status;

    `CFWS_ASSERT(a_count_le_depth, i_clk, i_rst_n, r_count <= CW'(cfws_pkg::DEPTH), "occupancy above capacity")
    `CFWS_ASSERT(a_ptrs_meet, i_clk, i_rst_n, (is_empty || is_full) |-> (r_head == r_tail), "head and tail apart while empty or full")
    `CFWS_ASSERT(a_emit_loads_out, i_clk, i_rst_n, i_cmd.emit |=> r_out_valid, "emitted result not held")
    `CFWS_ASSERT(a_scan_left_bound, i_clk, i_rst_n, i_cmd.scan |-> (r_scan_left <= r_count), "scan longer than occupancy")

endmodule

/* hw/rtl/circular_fifo_with_search.sv */
`timescale 1ns / 1ps

// FIFO of signed 32-bit words kept in a 128-entry circular RAM. Each input
// word is a request: push a value, pop the oldest value, or search the
// occupied entries for a value. Every request gives exactly one result word
// with a status (done, refused because full, refused because empty), the
// oldest and newest entries (0 when empty), a found flag (searches only),
// the occupancy and the empty and full flags. Requests are handled one at
// a time, with the entry RAM's single read port setting the cost. A push
// goes straight to the result; a pop does one RAM read to fetch the new
// oldest entry. A search reads the RAM once per occupied entry, compares
// the last read, then sees the scan end before the result. Request code 3
// is ignored. A result sits in an output register, so the next request is
// taken while the previous result still waits on the master side; a
// request finishing while that register is still held waits in its last
// cycle until the master side frees it. The RAM needs no clearing after
// reset: a result never shows an entry that is not occupied.

module circular_fifo_with_search (
    input  logic                             i_clk,
    input  logic                             i_rst_n,

    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // [31:0] value
    input  logic [cfws_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // [1:0] req_type
    input  logic [cfws_pkg::REQ_W-1:0]       s_axis_tuser,

    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [31:0] front_value, [63:32] rear_value, [64] found,
    // [72:65] occupancy, [73] is_empty, [74] is_full, [79:75] zero
    output logic [cfws_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    // [1:0] status
    output logic [cfws_pkg::STS_W-1:0]       m_axis_tuser
);

    cfws_pkg::t_cmd cmd;
    cfws_pkg::t_sts sts;

    // Sequencer: accept, fetch front or scan, then hand the result over.
    cfws_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .i_req   (s_axis_tuser),
        .o_ready (s_axis_tready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    // Pointers, count, cached front/rear, search compare and output register.
    cfws_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_req        (s_axis_tuser),
        .i_value      (s_axis_tdata),
        .o_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .o_out_data   (m_axis_tdata),
        .o_out_status (m_axis_tuser)
    );

endmodule

/* test/tb_top.sv */
`timescale 1ns / 1ps

// Self-checking bench for circular_fifo_with_search. A queue of request words
// is built up front: a short directed opening, then random episodes that fill
// the FIFO to full, drain it to empty, mix requests, or search hard.
// The driver predicts each accepted request as it goes, and the monitor checks
// every result word against the oldest prediction, field by field.

module tb_top;
    import cfws_pkg::*;

    // Request code 3 is unused; the block must ignore it.
    localparam logic [REQ_W-1:0] REQ_NONE = 2'd3;

    localparam int RANDOM_WORDS = 1600;
    localparam int IDLE_LIMIT   = 5000;
    localparam int SETTLE_CYCLES = 200;
    localparam int HOLD_CYCLES  = 600;

    typedef struct {
        logic [REQ_W-1:0]  req;
        logic [DATA_W-1:0] value;
        bit                drain;   // hold this word until all results are back
    } fifo_request_t;

    typedef struct {
        logic [STS_W-1:0]  status;
        logic [DATA_W-1:0] front;
        logic [DATA_W-1:0] rear;
        logic              found;
        logic [OCC_W-1:0]  occupancy;
        logic              empty;
        logic              full;
    } fifo_result_t;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;
    logic [REQ_W-1:0]       s_tuser = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic [STS_W-1:0]       m_tuser;

    fifo_request_t queued_requests[$];
    fifo_result_t  awaited_results[$];

    // Shadow of the contents while the stimulus is built, used to aim searches
    // at live values and to know when the FIFO is full or empty.
    logic [DATA_W-1:0] planned_contents[$];
    int  planned_words = 0;
    bit  next_drain = 1'b0;

    // Predictor state
    logic [DATA_W-1:0] model_words [DEPTH];
    int  oldest_idx = 0;
    int  write_idx = 0;
    int  live_count = 0;

    int  words_in = 0;
    int  results_out = 0;
    int  mismatches = 0;
    int  idle_cycles = 0;
    int  send_gap = 0;
    int  recv_stall = 0;
    bit  send_calm = 1'b0;
    bit  recv_calm = 1'b0;
    int  hold_cnt = 0;
    int  holds_done = 0;

    circular_fifo_with_search u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_tready),
        .s_axis_tdata  (s_tdata),
        .s_axis_tuser  (s_tuser),
        .m_axis_tvalid (m_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_tdata),
        .m_axis_tuser  (m_tuser)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------------
    // Predictor: apply one request to the model FIFO, return its result word
    // ---------------------------------------------------------------------
    function automatic fifo_result_t fifo_step_result(logic [REQ_W-1:0] req,
                                                      logic [DATA_W-1:0] value);
        fifo_result_t r;
        int idx;
        r = '{status: ST_DONE, front: '0, rear: '0, found: 1'b0,
              occupancy: '0, empty: 1'b0, full: 1'b0};
        case (req)
            REQ_PUSH: begin
                if (live_count >= DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    model_words[write_idx] = value;
                    write_idx = (write_idx + 1) % DEPTH;
                    live_count++;
                end
            end
            REQ_POP: begin
                if (live_count == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    oldest_idx = (oldest_idx + 1) % DEPTH;
                    live_count--;
                end
            end
            REQ_SEARCH: begin
                // Scan occupied entries only, oldest first.
                idx = oldest_idx;
                for (int n = 0; n < live_count; n++) begin
                    if (model_words[idx] == value)
                        r.found = 1'b1;
                    idx = (idx + 1) % DEPTH;
                end
            end
            default: ;
        endcase
        if (live_count != 0) begin
            r.front = model_words[oldest_idx];
            r.rear  = model_words[(write_idx + DEPTH - 1) % DEPTH];
        end
        r.occupancy = live_count[OCC_W-1:0];
        r.empty     = (live_count == 0);
        r.full      = (live_count == DEPTH);
        return r;
    endfunction

    // ---------------------------------------------------------------------
    // Stimulus building
    // ---------------------------------------------------------------------
    function automatic void add_request(logic [REQ_W-1:0] req, logic [DATA_W-1:0] value);
        fifo_request_t w;
        w.req   = req;
        w.value = value;
        w.drain = next_drain;
        next_drain = 1'b0;
        queued_requests.push_back(w);
        if (req == REQ_PUSH && planned_contents.size() < DEPTH)
            planned_contents.push_back(value);
        if (req == REQ_POP && planned_contents.size() > 0)
            void'(planned_contents.pop_front());
        if (req != REQ_NONE)
            planned_words++;
    endfunction

    // Mostly full-range values, with small values to force duplicates and
    // the corners of the signed range.
    function automatic logic [DATA_W-1:0] pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return $urandom;
        if (r < 85)
            return DATA_W'($signed($urandom_range(0, 15)) - 8);
        case ($urandom_range(0, 3))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h0000_0000;
            default: return 32'hFFFF_FFFF;
        endcase
    endfunction

    // Search for a live value about half the time so hits are common.
    function automatic logic [DATA_W-1:0] pick_search();
        if (planned_contents.size() > 0 && $urandom_range(0, 1) == 0)
            return planned_contents[$urandom_range(0, planned_contents.size() - 1)];
        return pick_value();
    endfunction

    // Gap lengths: mostly none or short, a few long; nothing in calm stretches.
    function automatic int pick_gap(bit calm);
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic report_mismatch(string msg);
        $display("mismatch: %s", msg);
        mismatches++;
    endtask

    task automatic build_stimulus();
        int kind;
        int r;
        // Directed opening: an empty-queue refusal, unused code, signed extremes,
        // hits and misses, a drain and one more refusal, then refill and empty again.
        add_request(REQ_POP,    32'h1234_5678);
        add_request(REQ_SEARCH, 32'h0000_0000);
        add_request(REQ_NONE,   32'hFFFF_FFFF);
        add_request(REQ_PUSH,   32'h8000_0000);
        add_request(REQ_PUSH,   32'h7FFF_FFFF);
        add_request(REQ_PUSH,   32'h0000_0000);
        add_request(REQ_PUSH,   32'hFFFF_FFFF);
        add_request(REQ_SEARCH, 32'h7FFF_FFFF);
        add_request(REQ_SEARCH, 32'h8000_0000);
        add_request(REQ_SEARCH, 32'h1234_5678);
        add_request(REQ_SEARCH, 32'h0000_0001);
        add_request(REQ_NONE,   32'h5A5A_A5A5);
        repeat (4) add_request(REQ_POP, 32'hDEAD_BEEF);
        add_request(REQ_POP,    32'h0000_0000);
        add_request(REQ_PUSH,   32'h5555_5555);
        add_request(REQ_PUSH,   32'hAAAA_AAAA);
        add_request(REQ_SEARCH, 32'hAAAA_AAAA);
        add_request(REQ_SEARCH, 32'h5555_5554);
        add_request(REQ_POP,    32'hFFFF_FFFF);
        add_request(REQ_POP,    32'h0000_0000);

        // The first random word waits until the directed results are all back.
        next_drain = 1'b1;
        planned_words = 0;
        while (planned_words < RANDOM_WORDS) begin
            if ($urandom_range(0, 5) == 0)
                next_drain = 1'b1;
            kind = $urandom_range(0, 99);
            if (kind < 20) begin
                // Fill to full, then knock on the full queue.
                while (planned_contents.size() < DEPTH) begin
                    if ($urandom_range(0, 9) == 0)
                        add_request(REQ_SEARCH, pick_search());
                    else
                        add_request(REQ_PUSH, pick_value());
                end
                repeat ($urandom_range(1, 3)) add_request(REQ_PUSH, pick_value());
                add_request(REQ_SEARCH, pick_search());
            end else if (kind < 40) begin
                // Drain to empty, then pop the empty queue.
                while (planned_contents.size() > 0) begin
                    if ($urandom_range(0, 9) == 0)
                        add_request(REQ_SEARCH, pick_search());
                    else
                        add_request(REQ_POP, $urandom);
                end
                repeat ($urandom_range(1, 3)) add_request(REQ_POP, $urandom);
                add_request(REQ_SEARCH, pick_value());
            end else if (kind < 85) begin
                repeat ($urandom_range(20, 60)) begin
                    r = $urandom_range(0, 99);
                    if (r < 40)
                        add_request(REQ_PUSH, pick_value());
                    else if (r < 70)
                        add_request(REQ_POP, $urandom);
                    else if (r < 95)
                        add_request(REQ_SEARCH, pick_search());
                    else
                        add_request(REQ_NONE, $urandom);
                end
            end else begin
                repeat ($urandom_range(5, 15)) add_request(REQ_SEARCH, pick_search());
            end
        end
    endtask

    // ---------------------------------------------------------------------
    // Driver: present queued words, predict each one as it is accepted
    // ---------------------------------------------------------------------
    always @(posedge i_clk) begin
        fifo_request_t w;
        bit            offer;
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else begin
            offer = s_tvalid;
            if (s_tvalid && s_tready) begin
                awaited_results.push_back(fifo_step_result(s_tuser, s_tdata));
                words_in++;
                offer = 1'b0;
                send_gap = pick_gap(send_calm);
                if ($urandom_range(0, 149) == 0)
                    send_calm = !send_calm;
            end
            if (!offer) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (queued_requests.size() > 0 &&
                             !(queued_requests[0].drain && awaited_results.size() > 0)) begin
                    // A drain word waits until every earlier result has come back.
                    w = queued_requests.pop_front();
                    s_tdata <= w.value;
                    s_tuser <= w.req;
                    offer = 1'b1;
                end
            end
            s_tvalid <= offer;
        end
    end

    // Long receiver hold-offs: the sender keeps offering, so the block backs
    // up and has to drop its input ready.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_cnt   <= 0;
            holds_done <= 0;
        end else if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
        end else if (holds_done < 2 && words_in >= (holds_done == 0 ? 400 : 1100)) begin
            hold_cnt   <= HOLD_CYCLES;
            holds_done <= holds_done + 1;
        end
    end

    // ---------------------------------------------------------------------
    // Monitor: stall at random, check each result against the oldest prediction
    // ---------------------------------------------------------------------
    always @(posedge i_clk) begin
        fifo_result_t want;
        bit           ready;
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (awaited_results.size() == 0) begin
                    report_mismatch($sformatf("result %0d arrived with nothing expected",
                                              results_out));
                end else begin
                    want = awaited_results.pop_front();
                    if (m_tuser !== want.status)
                        report_mismatch($sformatf("result %0d status %h, expected %h",
                                                  results_out, m_tuser, want.status));
                    if (m_tdata[31:0] !== want.front)
                        report_mismatch($sformatf("result %0d front %h, expected %h",
                                                  results_out, m_tdata[31:0], want.front));
                    if (m_tdata[63:32] !== want.rear)
                        report_mismatch($sformatf("result %0d rear %h, expected %h",
                                                  results_out, m_tdata[63:32], want.rear));
                    if (m_tdata[64] !== want.found)
                        report_mismatch($sformatf("result %0d found %b, expected %b",
                                                  results_out, m_tdata[64], want.found));
                    if (m_tdata[72:65] !== want.occupancy)
                        report_mismatch($sformatf("result %0d occupancy %0d, expected %0d",
                                                  results_out, m_tdata[72:65],
                                                  want.occupancy));
                    if (m_tdata[73] !== want.empty)
                        report_mismatch($sformatf("result %0d empty %b, expected %b",
                                                  results_out, m_tdata[73], want.empty));
                    if (m_tdata[74] !== want.full)
                        report_mismatch($sformatf("result %0d full %b, expected %b",
                                                  results_out, m_tdata[74], want.full));
                    if (m_tdata[79:75] !== '0)
                        report_mismatch($sformatf("result %0d pad bits %b, expected zero",
                                                  results_out, m_tdata[79:75]));
                end
                results_out++;
            end
            ready = 1'b1;
            if (hold_cnt > 0) begin
                ready = 1'b0;
            end else if (recv_stall > 0) begin
                recv_stall--;
                ready = 1'b0;
            end else if (!recv_calm && $urandom_range(0, 4) == 0) begin
                recv_stall = pick_gap(1'b0);
                ready = (recv_stall == 0);
            end
            if ($urandom_range(0, 299) == 0)
                recv_calm = !recv_calm;
            m_tready <= ready;
        end
    end

    // Watchdog: end the run when nothing moves on either side for too long.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
                if (idle_cycles >= IDLE_LIMIT) begin
                    $display("watchdog: no word moved for %0d cycles", IDLE_LIMIT);
                    $display("end of test: mismatches");
                    $finish;
                end
            end
        end
    end

    // ---------------------------------------------------------------------
    // Sequencing: build stimulus, release reset, wait out the run
    // ---------------------------------------------------------------------
    initial begin
        build_stimulus();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (queued_requests.size() > 0 || s_tvalid)
            @(posedge i_clk);
        while (awaited_results.size() > 0)
            @(posedge i_clk);
        // Catch any stray result the block might still emit.
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
